FILE: hdl/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned SKIP_W = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_SEED_RST = 16'hFFFF;
  localparam logic [SKIP_W-1:0] SKIP_RST    = 4'd2;
  localparam logic [POS_W-1:0]  POS_MAX     = 4'd15;

  localparam logic [BYTE_W-1:0] CHAR_STAR    = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A_LESS_TEN = 8'h37;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LEADING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED     = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } out_item_t;

  // one input item and its accept flag, as seen by the crc unit
  typedef struct packed {
    logic              acc;
    logic              last;
    logic [BYTE_W-1:0] data;
  } crc_step_t;

  typedef enum logic [2:0] {
    TRL_IDLE,
    TRL_STAR,
    TRL_H3,
    TRL_H2,
    TRL_H1,
    TRL_H0,
    TRL_NL
  } trl_state_t;

  // msb-first crc over one byte, eight shift steps
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // uppercase hex character of one nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + {4'd0, nib};
    end else begin
      r = CHAR_A_LESS_TEN + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tcf_crc_unit.sv
`default_nettype none

module tcf_crc_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tcf_pkg::crc_step_t           step,
  input  wire logic [tcf_pkg::SKIP_W-1:0]   skip_leading,
  input  wire logic [tcf_pkg::CRC_W-1:0]    crc_seed,
  output logic      [tcf_pkg::CRC_W-1:0]    crc_cur
);
  import tcf_pkg::*;

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CRC_W-1:0] crc_start;

  // line start takes the seed as it stands now
  always_comb begin
    crc_start = (pos_r == '0) ? crc_seed : crc_r;
    crc_cur   = (pos_r >= skip_leading) ? crc16_byte(crc_start, step.data) : crc_start;
  end

  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    if (step.acc) begin
      if (step.last) begin
        crc_nxt = crc_seed;
        pos_nxt = '0;
      end else begin
        crc_nxt = crc_cur;
        pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_SEED_RST;
      pos_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/telemetry_crc16_trailer_framer.sv
`default_nettype none

// channel   dir  handshake                payload
// in_       in   in_valid / in_stall      in_item  (in_byte, in_last)
// out_      out  out_valid / out_stall    out_item (out_byte, out_last)
// cfg_      in   cfg_we                   cfg_index, cfg_wdata
//
// one byte is taken per clock while in_stall is low; its copy appears on the output in the next cycle
// a byte flagged last is followed by six trailer items ('*', four hex digits,
// newline); the trailer sequencer holds in_stall high until the newline is loaded
// out_stall reaches in_stall combinationally, gated by the valid flag of the single output register
// reset (synchronous, active low) clears the output valid flag, trailer sequencer,
// line position, and loads skip_leading = 2 and crc_seed = 0xFFFF

module telemetry_crc16_trailer_framer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tcf_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tcf_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_we,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tcf_pkg::*;

  // configuration registers
  logic [SKIP_W-1:0] skip_r;
  logic [CRC_W-1:0]  seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RST;
      seed_r <= CRC_SEED_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SKIP_LEADING) begin
        skip_r <= cfg_wdata[SKIP_W-1:0];
      end
      if (cfg_index == REG_CRC_SEED) begin
        seed_r <= cfg_wdata[CRC_W-1:0];
      end
    end
  end

  // output register and trailer sequencer
  trl_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [CRC_W-1:0] trl_crc_r;
  logic [CRC_W-1:0] crc_cur;
  logic             adv;
  logic             in_acc;
  crc_step_t        step;

  // output slot can be loaded this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !(adv && (state_r == TRL_IDLE));
  assign in_acc   = in_valid && !in_stall;

  assign step.acc  = in_acc;
  assign step.last = in_item.in_last;
  assign step.data = in_item.in_byte;

  tcf_crc_unit u_crc (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .skip_leading (skip_r),
    .crc_seed     (seed_r),
    .crc_cur      (crc_cur)
  );

  // crc of the finished line, held while the trailer goes out
  always_ff @(posedge clk) begin
    if (in_acc && in_item.in_last) begin
      trl_crc_r <= crc_cur;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (adv) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.out_last = 1'b0;
      case (state_r)
        TRL_IDLE: begin
          out_valid_nxt         = in_valid;
          out_item_nxt.out_byte = in_item.in_byte;
          if (in_valid && in_item.in_last) begin
            state_nxt = TRL_STAR;
          end
        end
        TRL_STAR: begin
          out_item_nxt.out_byte = CHAR_STAR;
          state_nxt             = TRL_H3;
        end
        TRL_H3: begin
          out_item_nxt.out_byte = hex_char(trl_crc_r[15:12]);
          state_nxt             = TRL_H2;
        end
        TRL_H2: begin
          out_item_nxt.out_byte = hex_char(trl_crc_r[11:8]);
          state_nxt             = TRL_H1;
        end
        TRL_H1: begin
          out_item_nxt.out_byte = hex_char(trl_crc_r[7:4]);
          state_nxt             = TRL_H0;
        end
        TRL_H0: begin
          out_item_nxt.out_byte = hex_char(trl_crc_r[3:0]);
          state_nxt             = TRL_NL;
        end
        TRL_NL: begin
          // newline closes the framed line
          out_item_nxt.out_byte = CHAR_NEWLINE;
          out_item_nxt.out_last = 1'b1;
          state_nxt             = TRL_IDLE;
        end
        default: begin
          out_valid_nxt = 1'b0;
          state_nxt     = TRL_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TRL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a last byte always starts the trailer
  a_last_starts_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.in_last |=> state_r == TRL_STAR)
    else $error("last byte did not start trailer");

  // trailer crc holds while the trailer is being sent
  a_trl_crc_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != TRL_IDLE |=> $stable(trl_crc_r))
    else $error("trailer crc changed mid-trailer");

  // only the newline carries the line-end flag
  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_last |-> out_item.out_byte == CHAR_NEWLINE)
    else $error("out_last on a byte other than newline");

  // leaving the newline state produces a flagged output
  a_nl_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == TRL_NL && adv |=> out_valid && out_item.out_last)
    else $error("newline not emitted with out_last");

endmodule

`default_nettype wire

FILE: tb/tcf_line_checker.sv
module tcf_line_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire tcf_pkg::in_item_t              in_item,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire tcf_pkg::out_item_t             out_item,
  input  wire logic                           cfg_we,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  err_count,
  output int                                  owed_count
);
  import tcf_pkg::*;

  localparam logic [BYTE_W-1:0] HEX_A = 8'h41;

  logic [SKIP_W-1:0] skip_len;
  logic [CRC_W-1:0]  seed_val;
  logic [CRC_W-1:0]  line_crc;
  logic [POS_W-1:0]  line_pos;
  out_item_t         owed_chars[$];
  int                errs = 0;

  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] ascii_hex(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + {4'd0, nib};
    end else begin
      r = HEX_A + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

  task automatic owe(input logic [BYTE_W-1:0] b, input logic l);
    out_item_t e;
    e.out_byte = b;
    e.out_last = l;
    owed_chars.push_back(e);
  endtask

  // one accepted line character and the trailer it may close
  task automatic frame_char(input logic [BYTE_W-1:0] b, input logic l);
    logic [CRC_W-1:0] c;
    c = (line_pos == '0) ? seed_val : line_crc;
    if (line_pos >= skip_len) begin
      c = crc_next(c, b);
    end
    if (line_pos != POS_MAX) begin
      line_pos = line_pos + POS_W'(1);
    end
    line_crc = c;
    owe(b, 1'b0);
    if (l) begin
      owe(CHAR_STAR, 1'b0);
      owe(ascii_hex(c[15:12]), 1'b0);
      owe(ascii_hex(c[11:8]), 1'b0);
      owe(ascii_hex(c[7:4]), 1'b0);
      owe(ascii_hex(c[3:0]), 1'b0);
      owe(CHAR_NEWLINE, 1'b1);
      line_crc = seed_val;
      line_pos = '0;
    end
  endtask

  task automatic flag(input string what, input out_item_t want);
    errs++;
    if (errs <= 10) begin
      $display("%s: expected byte %h last %b, got byte %h last %b", what,
               want.out_byte, want.out_last, out_item.out_byte, out_item.out_last);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      skip_len = SKIP_RST;
      seed_val = CRC_SEED_RST;
      line_crc = CRC_SEED_RST;
      line_pos = '0;
      owed_chars.delete();
    end else begin
      // an output item can never stem from an input taken at the same edge
      if (out_valid && !out_stall) begin
        if (owed_chars.size() == 0) begin
          flag("unexpected item", '0);
        end else begin
          want = owed_chars.pop_front();
          if (want.out_byte !== out_item.out_byte || want.out_last !== out_item.out_last) begin
            flag("mismatch", want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        frame_char(in_item.in_byte, in_item.in_last);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SKIP_LEADING: skip_len = cfg_wdata[SKIP_W-1:0];
          REG_CRC_SEED:     seed_val = cfg_wdata;
          default:          ;
        endcase
      end
    end
    err_count  <= errs;
    owed_count <= owed_chars.size();
  end

endmodule

FILE: tb/telemetry_crc16_trailer_framer_test.sv
module telemetry_crc16_trailer_framer_test;
  import tcf_pkg::*;

  // generous bound: every item a full line end, every output item a long stall
  localparam int RUN_LIMIT  = 600000;
  // receiver hold-off starts once this many items went in, during a gap-free phase
  localparam int HOLD_AT    = 135;
  localparam int HOLD_LEN   = 150;
  localparam int PHASE_ITEMS = 65;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int owed;
  int sent_cnt  = 0;
  int cycle_cnt = 0;
  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_done = 1'b0;

  telemetry_crc16_trailer_framer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tcf_line_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .err_count  (mismatches),
    .owed_count (owed)
  );

  always #5 clk = ~clk;

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // half printable text, half any byte value
  function automatic logic [BYTE_W-1:0] pick_char();
    if ($urandom_range(0, 1) == 0) begin
      return BYTE_W'($urandom_range(32, 126));
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // offer one item, hold it until taken, then maybe drop valid for a while
  task automatic send_char(input logic [BYTE_W-1:0] b, input logic l);
    int gap;
    in_item  <= '{in_byte: b, in_last: l};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every owed output item come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int line_len;
    int phase_cnt;
    int r;
    logic [SKIP_W-1:0] skip_sel;
    logic [CRC_W-1:0]  seed_sel;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: "$$" prefix left out of the checksum
    send_char("$", 1'b0);
    send_char("$", 1'b0);
    send_char("A", 1'b0);
    send_char("B", 1'b1);
    // line ending inside the skipped prefix, crc stays at the seed
    send_char(8'hFF, 1'b1);
    settle();

    // no skip, zero seed, then seed and skip changed in the middle of a line
    write_reg(REG_SKIP_LEADING, CFG_DATA_W'(0));
    write_reg(REG_CRC_SEED, 16'h0000);
    send_char(8'h00, 1'b0);
    settle();
    write_reg(REG_CRC_SEED, 16'hFFFF);
    write_reg(REG_SKIP_LEADING, CFG_DATA_W'(2));
    send_char(8'h80, 1'b1);
    settle();

    // maximum skip on a line long enough to saturate the position
    write_reg(REG_SKIP_LEADING, CFG_DATA_W'(15));
    write_reg(REG_CRC_SEED, 16'h1D0F);
    for (int i = 0; i < 17; i++) begin
      send_char(pick_char(), i == 16);
    end
    settle();

    // random lines under several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin skip_sel = SKIP_RST; seed_sel = CRC_SEED_RST; end
        1: begin skip_sel = 4'd0;     seed_sel = 16'h0000;     end
        2: begin skip_sel = 4'd15;    seed_sel = 16'hFFFF;     end
        3: begin skip_sel = 4'd1;     seed_sel = 16'h8000;     end
        default: begin
          skip_sel = SKIP_W'($urandom_range(0, 15));
          seed_sel = CRC_W'($urandom_range(0, 65535));
        end
      endcase
      write_reg(REG_SKIP_LEADING, CFG_DATA_W'(skip_sel));
      write_reg(REG_CRC_SEED, seed_sel);
      // phase 1 sends back to back (the hold-off lands here), phase 2 never stalls
      tx_gaps   = (ph != 1);
      rx_stalls = (ph != 2);
      phase_cnt = 0;
      while (phase_cnt < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          line_len = $urandom_range(1, 20);
        end else if (r < 95) begin
          line_len = $urandom_range(21, 40);
        end else begin
          line_len = $urandom_range(1, 2);
        end
        for (int k = 0; k < line_len; k++) begin
          send_char(pick_char(), k == line_len - 1);
        end
        phase_cnt += line_len;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall_len;
    int held;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_LEN) begin
          @(posedge clk);
          held++;
        end
      end else begin
        stall_len = rx_stalls ? pick_gap() : 0;
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
